>>> hdl/fal_pkg.sv
// Shared types, constants and sizes for the frame allowlist and ICMP limit filter.
package fal_pkg;

    localparam int ALLOW_ENTRIES = 256;
    localparam int ALLOW_IDX_W   = (ALLOW_ENTRIES > 1) ? $clog2(ALLOW_ENTRIES) : 1;
    localparam int ALLOW_CNT_W   = $clog2(ALLOW_ENTRIES + 1);

    localparam int RATE_ENTRIES  = 4096;
    localparam int RATE_IDX_W    = $clog2(RATE_ENTRIES);
    localparam int RATE_CNT_W    = $clog2(RATE_ENTRIES + 1);
    localparam int RANK_W        = RATE_IDX_W;

    localparam int PTR_W = (ALLOW_CNT_W > RATE_CNT_W) ? ALLOW_CNT_W : RATE_CNT_W;

    localparam int PADDR_W = 3;
    localparam logic REG_ICMP_LIMIT = 1'b0;

    localparam logic [15:0] LIMIT_RESET = 16'd100;
    localparam logic [13:0] MIN_ETH     = 14'd14;
    localparam logic [13:0] MIN_ARP     = 14'd22;
    localparam logic [13:0] MIN_IPV4    = 14'd34;
    localparam logic [15:0] TYPE_ARP    = 16'h0806;
    localparam logic [15:0] TYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP  = 8'd1;

    localparam logic [1:0] CMD_FRAME  = 2'd0;
    localparam logic [1:0] CMD_SET    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] CAUSE_NONE      = 2'd0;
    localparam logic [1:0] CAUSE_ARP_SHORT = 2'd1;
    localparam logic [1:0] CAUSE_ARP_DENY  = 2'd2;
    localparam logic [1:0] CAUSE_ICMP_OVER = 2'd3;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_MISSING = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [13:0] frame_length;
        logic [15:0] ether_type;
        logic [47:0] source_mac;
        logic [7:0]  ip_protocol;
        logic [31:0] source_ip;
        logic [7:0]  allow_value;
    } in_word_t;

    typedef struct packed {
        logic        verdict;
        logic [1:0]  cause;
        logic [1:0]  table_status;
    } out_word_t;

    typedef struct packed {
        logic [47:0] key;
        logic [7:0]  value;
    } allow_entry_t;

    typedef struct packed {
        logic [31:0]       key;
        logic [15:0]       count;
        logic [RANK_W-1:0] rank;
    } rate_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_A_READ,
        ST_A_CHECK,
        ST_A_APPLY,
        ST_R_READ,
        ST_R_CHECK,
        ST_T_READ,
        ST_T_WRITE,
        ST_FINISH
    } state_t;

endpackage

>>> hdl/fal_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module fal_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/fal_apb_regs.sv
// APB register block holding the ICMP limit.
module fal_apb_regs
    import fal_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [15:0]        icmp_limit
);

    logic [15:0] limit_reg;
    logic [15:0] limit_next;
    logic        wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_ICMP_LIMIT);

    always_comb begin
        limit_next = limit_reg;
        if (wr_hit) begin
            limit_next = pwdata[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else begin
            limit_reg <= limit_next;
        end
    end

    // return zero for addresses past the register list
    assign prdata = (paddr[2] == REG_ICMP_LIMIT) ? {16'd0, limit_reg} : 32'd0;
    assign icmp_limit = limit_reg;

endmodule

>>> hdl/frame_allowlist_icmp_limit_filter_unit.sv
// Top level of the frame allowlist and ICMP limit filter: sequencer and tables.
//
//  channel | ports              | word        | direction
//  --------+--------------------+-------------+----------
//  input   | s_valid/s_ready    | in_word_t   | in
//  result  | m_valid/m_ready    | out_word_t  | out
//  config  | psel..pready (APB) | icmp_limit  | in
//
// Per word: commands and ARP lookups sweep the whole allowlist RAM, reading and
// then checking each entry. An ICMP frame scans the used part of the rate RAM
// up to a hit or its end, then runs an aging pass over all used entries. Other
// frames go straight from decode to the result. Reset is synchronous: allowlist
// valid flops and the rate fill count clear at once, so no clearing pass runs.
// A stalled result waits in the output register while the next word is
// accepted and processed.
module frame_allowlist_icmp_limit_filter_unit
    import fal_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_word_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_word_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    state_t state_reg, state_next;

    in_word_t  in_reg;
    out_word_t res_reg, res_next;
    out_word_t m_data_reg;
    logic      m_valid_reg;
    logic      out_free;

    logic [PTR_W-1:0] ptr_reg, ptr_next;

    // allowlist scan state
    logic                   found_reg, found_next;
    logic [ALLOW_IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [7:0]             hit_val_reg, hit_val_next;
    logic                   free_found_reg, free_found_next;
    logic [ALLOW_IDX_W-1:0] free_idx_reg, free_idx_next;
    logic                   allow_valid_reg [ALLOW_ENTRIES];

    // rate table state
    logic [RATE_CNT_W-1:0] fill_reg, fill_next;
    logic [RATE_IDX_W-1:0] slot_reg, slot_next;
    logic [RATE_CNT_W-1:0] old_rank_reg, old_rank_next;
    logic [RATE_IDX_W-1:0] oldest_reg, oldest_next;
    logic [RANK_W-1:0]     oldest_rank_reg, oldest_rank_next;
    logic                  have_old_reg, have_old_next;
    logic [15:0]           count_new_reg, count_new_next;

    // memory ports
    logic                   a_we;
    logic [ALLOW_IDX_W-1:0] a_waddr;
    allow_entry_t           a_wdata, a_rdata;
    logic                   r_we;
    logic [RATE_IDX_W-1:0]  r_waddr;
    rate_entry_t            r_wdata, r_rdata;

    logic                   a_set, a_clr;
    logic [ALLOW_IDX_W-1:0] a_vidx;

    logic [15:0] icmp_limit;

    logic a_last, r_last, t_last, rate_frame, is_arp;
    logic [16:0] count_inc;
    logic [RATE_IDX_W-1:0] cand_idx;
    logic [RANK_W-1:0]     cand_rank;
    logic                  cur_valid;

    fal_apb_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .icmp_limit (icmp_limit)
    );

    fal_ram #(
        .DEPTH (ALLOW_ENTRIES),
        .WIDTH ($bits(allow_entry_t)),
        .ADDR_W(ALLOW_IDX_W)
    ) u_allow_ram (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (ptr_reg[ALLOW_IDX_W-1:0]),
        .rdata (a_rdata)
    );

    fal_ram #(
        .DEPTH (RATE_ENTRIES),
        .WIDTH ($bits(rate_entry_t)),
        .ADDR_W(RATE_IDX_W)
    ) u_rate_ram (
        .aclk  (aclk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (ptr_reg[RATE_IDX_W-1:0]),
        .rdata (r_rdata)
    );

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    assign is_arp     = (in_reg.ether_type == TYPE_ARP);
    assign rate_frame = (in_reg.ether_type == TYPE_IPV4) && (in_reg.frame_length >= MIN_IPV4)
                        && (in_reg.ip_protocol == PROTO_ICMP);
    assign a_last     = (ptr_reg == PTR_W'(ALLOW_ENTRIES - 1));
    assign r_last     = (ptr_reg == PTR_W'(fill_reg - 1'b1));
    assign t_last     = r_last;
    assign count_inc  = {1'b0, r_rdata.count} + 17'd1;
    assign cur_valid  = allow_valid_reg[ptr_reg[ALLOW_IDX_W-1:0]];

    // oldest entry seen so far, including the one on the read port
    always_comb begin
        cand_idx  = oldest_reg;
        cand_rank = oldest_rank_reg;
        if (!have_old_reg || (r_rdata.rank > oldest_rank_reg)) begin
            cand_idx  = ptr_reg[RATE_IDX_W-1:0];
            cand_rank = r_rdata.rank;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_FINISH;
                if ((in_reg.command == CMD_SET) || (in_reg.command == CMD_REMOVE)) begin
                    state_next = ST_A_READ;
                end else if ((in_reg.command == CMD_FRAME)
                             && (in_reg.frame_length >= MIN_ETH)) begin
                    if (is_arp) begin
                        if (in_reg.frame_length >= MIN_ARP) begin
                            state_next = ST_A_READ;
                        end
                    end else if (rate_frame) begin
                        state_next = (fill_reg == '0) ? ST_T_READ : ST_R_READ;
                    end
                end
            end
            ST_A_READ:  state_next = ST_A_CHECK;
            ST_A_CHECK: state_next = a_last ? ST_A_APPLY : ST_A_READ;
            ST_A_APPLY: state_next = ST_FINISH;
            ST_R_READ:  state_next = ST_R_CHECK;
            ST_R_CHECK: begin
                if ((r_rdata.key == in_reg.source_ip) || r_last) begin
                    state_next = ST_T_READ;
                end else begin
                    state_next = ST_R_READ;
                end
            end
            ST_T_READ:  state_next = ST_T_WRITE;
            ST_T_WRITE: state_next = t_last ? ST_FINISH : ST_T_READ;
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        ptr_next         = ptr_reg;
        res_next         = res_reg;
        found_next       = found_reg;
        hit_idx_next     = hit_idx_reg;
        hit_val_next     = hit_val_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        fill_next        = fill_reg;
        slot_next        = slot_reg;
        old_rank_next    = old_rank_reg;
        oldest_next      = oldest_reg;
        oldest_rank_next = oldest_rank_reg;
        have_old_next    = have_old_reg;
        count_new_next   = count_new_reg;
        a_we    = 1'b0;
        a_waddr = hit_idx_reg;
        a_wdata = '{key: in_reg.source_mac, value: in_reg.allow_value};
        a_set   = 1'b0;
        a_clr   = 1'b0;
        a_vidx  = hit_idx_reg;
        r_we    = 1'b0;
        r_waddr = ptr_reg[RATE_IDX_W-1:0];
        r_wdata = r_rdata;

        unique case (state_reg)
            ST_DECODE: begin
                ptr_next        = '0;
                found_next      = 1'b0;
                free_found_next = 1'b0;
                have_old_next   = 1'b0;
                res_next        = '{verdict: 1'b0, cause: CAUSE_NONE, table_status: STAT_DONE};
                if ((in_reg.command == CMD_FRAME) && (in_reg.frame_length >= MIN_ETH)
                    && is_arp && (in_reg.frame_length < MIN_ARP)) begin
                    res_next.verdict = 1'b1;
                    res_next.cause   = CAUSE_ARP_SHORT;
                end
                // empty rate table: insert at slot zero directly
                if ((in_reg.command == CMD_FRAME) && (in_reg.frame_length >= MIN_ETH)
                    && !is_arp && rate_frame && (fill_reg == '0)) begin
                    slot_next      = '0;
                    old_rank_next  = '0;
                    fill_next      = RATE_CNT_W'(1);
                    count_new_next = 16'd1;
                end
            end
            ST_A_CHECK: begin
                if (cur_valid && (a_rdata.key == in_reg.source_mac) && !found_reg) begin
                    found_next   = 1'b1;
                    hit_idx_next = ptr_reg[ALLOW_IDX_W-1:0];
                    hit_val_next = a_rdata.value;
                end
                if (!cur_valid && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = ptr_reg[ALLOW_IDX_W-1:0];
                end
                if (!a_last) begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_A_APPLY: begin
                case (in_reg.command)
                    CMD_SET: begin
                        if (found_reg) begin
                            a_we    = 1'b1;
                            a_waddr = hit_idx_reg;
                        end else if (free_found_reg) begin
                            a_we    = 1'b1;
                            a_waddr = free_idx_reg;
                            a_set   = 1'b1;
                            a_vidx  = free_idx_reg;
                        end else begin
                            res_next.table_status = STAT_FULL;
                        end
                    end
                    CMD_REMOVE: begin
                        if (found_reg) begin
                            a_clr  = 1'b1;
                            a_vidx = hit_idx_reg;
                        end else begin
                            res_next.table_status = STAT_MISSING;
                        end
                    end
                    default: begin
                        if (found_reg && (hit_val_reg == 8'd0)) begin
                            res_next.verdict = 1'b1;
                            res_next.cause   = CAUSE_ARP_DENY;
                        end
                    end
                endcase
            end
            ST_R_CHECK: begin
                if (r_rdata.key == in_reg.source_ip) begin
                    slot_next     = ptr_reg[RATE_IDX_W-1:0];
                    old_rank_next = RATE_CNT_W'(r_rdata.rank);
                    ptr_next      = '0;
                    if (count_inc > {1'b0, icmp_limit}) begin
                        res_next.verdict = 1'b1;
                        res_next.cause   = CAUSE_ICMP_OVER;
                        count_new_next   = r_rdata.count;
                    end else begin
                        count_new_next = count_inc[15:0];
                    end
                end else begin
                    oldest_next      = cand_idx;
                    oldest_rank_next = cand_rank;
                    have_old_next    = 1'b1;
                    if (r_last) begin
                        ptr_next       = '0;
                        count_new_next = 16'd1;
                        if (fill_reg < RATE_CNT_W'(RATE_ENTRIES)) begin
                            slot_next     = fill_reg[RATE_IDX_W-1:0];
                            old_rank_next = fill_reg;
                            fill_next     = fill_reg + 1'b1;
                        end else begin
                            // table full: replace the least recent entry
                            slot_next     = cand_idx;
                            old_rank_next = RATE_CNT_W'(cand_rank);
                        end
                    end else begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
            end
            ST_T_WRITE: begin
                if (ptr_reg[RATE_IDX_W-1:0] == slot_reg) begin
                    r_we    = 1'b1;
                    r_wdata = '{key: in_reg.source_ip, count: count_new_reg, rank: '0};
                end else if (RATE_CNT_W'(r_rdata.rank) < old_rank_reg) begin
                    r_we         = 1'b1;
                    r_wdata.rank = r_rdata.rank + 1'b1;
                end
                if (!t_last) begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            fill_reg    <= '0;
            for (int i = 0; i < ALLOW_ENTRIES; i++) begin
                allow_valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (a_set) begin
                allow_valid_reg[a_vidx] <= 1'b1;
            end
            if (a_clr) begin
                allow_valid_reg[a_vidx] <= 1'b0;
            end
            // load the result, or drop it once taken
            if ((state_reg == ST_FINISH) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE) && s_valid) begin
            in_reg <= s_data;
        end
        if ((state_reg == ST_FINISH) && out_free) begin
            m_data_reg <= res_reg;
        end
        ptr_reg         <= ptr_next;
        res_reg         <= res_next;
        found_reg       <= found_next;
        hit_idx_reg     <= hit_idx_next;
        hit_val_reg     <= hit_val_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        slot_reg        <= slot_next;
        old_rank_reg    <= old_rank_next;
        oldest_reg      <= oldest_next;
        oldest_rank_reg <= oldest_rank_next;
        have_old_reg    <= have_old_next;
        count_new_reg   <= count_new_next;
    end

endmodule
